[sv/recm_pkg.sv]
`default_nettype none

package recm_pkg;

  // Image geometry. The line stores are addressed by the low bits of a raster
  // position, so the side is a power of two.
  localparam int IMAGE_SIDE   = 64;
  localparam int LINE_AW      = $clog2(IMAGE_SIDE);
  localparam int FRAME_PIXELS = IMAGE_SIDE * IMAGE_SIDE;
  localparam int LAG          = IMAGE_SIDE + 1;
  localparam int ADV_LAST     = FRAME_PIXELS + IMAGE_SIDE;
  localparam int POS_W        = $clog2(ADV_LAST + 1);
  localparam int Q_W          = $clog2(FRAME_PIXELS);
  localparam int CNT_W        = $clog2(FRAME_PIXELS + 1);
  localparam int FLUSH_W      = $clog2(LAG);

  localparam int PIX_W        = 8;
  localparam int WIN_N        = 8;

  // Queue and pipeline sizes.
  localparam int MQ_DEPTH     = 4;
  localparam int MQ_AW        = $clog2(MQ_DEPTH);
  localparam int MQ_CW        = $clog2(MQ_DEPTH + 1);
  localparam int OQ_DEPTH     = 8;
  localparam int OQ_AW        = $clog2(OQ_DEPTH);
  localparam int OQ_CW        = $clog2(OQ_DEPTH + 1);
  localparam int SORT_STAGES  = 3;
  localparam int SORT_CW      = $clog2(SORT_STAGES + 1);
  localparam int INFL_W       = $clog2(SORT_STAGES + 2);

  // Request kinds.
  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_RECT_LEFT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RECT_TOP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RECT_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RECT_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_MEAN     = 3'd4;
  localparam int CORNER_W = 6;
  localparam int LEN_W    = 7;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic [CORNER_W-1:0] rect_left;
    logic [CORNER_W-1:0] rect_top;
    logic [LEN_W-1:0]    rect_width;
    logic [LEN_W-1:0]    rect_height;
    pix_t                background_mean;
  } cfg_t;

  typedef struct packed {
    logic has_result;
    pix_t pixel;
  } mid_item_t;

  typedef logic [WIN_N-1:0][PIX_W-1:0] win_t;

  typedef struct packed {
    logic               filt;
    pix_t               centre;
    logic               last;
    logic [LINE_AW-1:0] addr;
  } meta_t;

  typedef struct packed {
    logic  valid;
    meta_t meta;
    win_t  vals;
  } sort_req_t;

  typedef struct packed {
    logic  valid;
    meta_t meta;
    pix_t  lo;
    pix_t  hi;
  } sort_res_t;

  typedef struct packed {
    logic [CNT_W-1:0] in_count;
  } front_stat_t;

  typedef struct packed {
    logic [OQ_CW-1:0]  oq_count;
    logic [INFL_W-1:0] inflight;
  } back_stat_t;

endpackage

`default_nettype wire

[sv/recm_front.sv]
`default_nettype none

module recm_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire logic              mode,
  input  wire recm_pkg::pix_t    pixel_in,
  output logic                   full,
  output recm_pkg::mid_item_t    head,
  output logic                   head_valid,
  input  wire logic              head_pop,
  output recm_pkg::front_stat_t  stat
);
  import recm_pkg::*;

  logic [CNT_W-1:0]   in_count;
  logic [FLUSH_W-1:0] fl_count;
  mid_item_t          mq [MQ_DEPTH];
  logic [MQ_AW-1:0]   wp;
  logic [MQ_AW-1:0]   rp;
  logic [MQ_CW-1:0]   count;

  logic      accept;
  logic      keep;
  logic      frame_in;
  logic      enq;
  logic      deq;
  mid_item_t item;

  assign full       = (count == MQ_CW'(MQ_DEPTH));
  assign accept     = push && !full;
  assign frame_in   = (in_count == CNT_W'(FRAME_PIXELS));
  assign head       = mq[rp];
  assign head_valid = (count != '0);
  assign deq        = head_pop && head_valid;
  assign enq        = accept && keep;
  assign stat.in_count = in_count;

  // Classify the request: pixels beyond a complete frame and flushes before
  // the frame is complete are dropped here and never reach the back end.
  always_comb begin
    item.pixel = pixel_in;
    unique case (mode)
      MODE_PIXEL: begin
        keep            = !frame_in;
        item.has_result = (in_count >= CNT_W'(LAG));
      end
      MODE_FLUSH: begin
        keep            = frame_in;
        item.has_result = 1'b1;
      end
      default: begin
        keep            = 1'b0;
        item.has_result = 1'b0;
      end
    endcase
  end

  // Frame counters: pixels taken, then flushes drained.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_count <= '0;
      fl_count <= '0;
    end else if (enq) begin
      if (mode == MODE_PIXEL) begin
        in_count <= in_count + CNT_W'(1);
      end else if (fl_count == FLUSH_W'(LAG - 1)) begin
        in_count <= '0;
        fl_count <= '0;
      end else begin
        fl_count <= fl_count + FLUSH_W'(1);
      end
    end
  end

  // Short queue towards the back end.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (enq) begin
        wp <= wp + MQ_AW'(1);
      end
      if (deq) begin
        rp <= rp + MQ_AW'(1);
      end
      count <= count + MQ_CW'(enq) - MQ_CW'(deq);
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      mq[wp] <= item;
    end
  end

endmodule

`default_nettype wire

[sv/recm_sort.sv]
`default_nettype none

module recm_sort (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire recm_pkg::sort_req_t   req,
  output recm_pkg::sort_res_t        res,
  output logic [recm_pkg::SORT_CW-1:0] pending
);
  import recm_pkg::*;

  logic  va;
  logic  vb;
  logic  vc;
  win_t  vals_a;
  win_t  vals_b;
  win_t  vals_c;
  meta_t meta_a;
  meta_t meta_b;
  meta_t meta_c;

  // One compare-exchange: the smaller value ends at the lower index.
  function automatic win_t cas(input win_t a, input logic [2:0] i, input logic [2:0] j);
    win_t r;
    r = a;
    if (a[i] > a[j]) begin
      r[i] = a[j];
      r[j] = a[i];
    end
    return r;
  endfunction

  // Odd-even merge network for eight values, two layers per stage.
  function automatic win_t layers_a(input win_t a);
    win_t r;
    r = a;
    r = cas(r, 3'd0, 3'd1);
    r = cas(r, 3'd2, 3'd3);
    r = cas(r, 3'd4, 3'd5);
    r = cas(r, 3'd6, 3'd7);
    r = cas(r, 3'd0, 3'd2);
    r = cas(r, 3'd1, 3'd3);
    r = cas(r, 3'd4, 3'd6);
    r = cas(r, 3'd5, 3'd7);
    return r;
  endfunction

  function automatic win_t layers_b(input win_t a);
    win_t r;
    r = a;
    r = cas(r, 3'd1, 3'd2);
    r = cas(r, 3'd5, 3'd6);
    r = cas(r, 3'd0, 3'd4);
    r = cas(r, 3'd1, 3'd5);
    r = cas(r, 3'd2, 3'd6);
    r = cas(r, 3'd3, 3'd7);
    return r;
  endfunction

  function automatic win_t layers_c(input win_t a);
    win_t r;
    r = a;
    r = cas(r, 3'd2, 3'd4);
    r = cas(r, 3'd3, 3'd5);
    r = cas(r, 3'd1, 3'd2);
    r = cas(r, 3'd3, 3'd4);
    r = cas(r, 3'd5, 3'd6);
    return r;
  endfunction

  // Valid bits of the three stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else begin
      va <= req.valid;
      vb <= va;
      vc <= vb;
    end
  end

  // Stage data; the pipeline never stalls.
  always_ff @(posedge clk) begin
    vals_a <= layers_a(req.vals);
    meta_a <= req.meta;
    vals_b <= layers_b(vals_a);
    meta_b <= meta_a;
    vals_c <= layers_c(vals_b);
    meta_c <= meta_b;
  end

  // The fourth and fifth smallest bound the median of nine.
  assign res.valid = vc;
  assign res.meta  = meta_c;
  assign res.lo    = vals_c[3];
  assign res.hi    = vals_c[4];
  assign pending   = SORT_CW'(va) + SORT_CW'(vb) + SORT_CW'(vc);

endmodule

`default_nettype wire

[sv/recm_back.sv]
`default_nettype none

module recm_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire recm_pkg::cfg_t      cfg,
  input  wire recm_pkg::mid_item_t head,
  input  wire logic                head_valid,
  output logic                     head_pop,
  output recm_pkg::pix_t           pixel_out,
  output logic                     frame_last,
  output logic                     empty,
  input  wire logic                pop,
  output recm_pkg::back_stat_t     stat
);
  import recm_pkg::*;

  localparam int EDGE_W = LEN_W + 2;

  // Advance position within the frame, including the drain by flushes.
  logic [POS_W-1:0]   adv_pos;
  logic [POS_W-1:0]   adv_pos_next;
  logic [POS_W-1:0]   q_full;
  logic               issue;
  logic               credit_ok;
  logic [INFL_W-1:0]  inflight;
  logic [SORT_CW-1:0] pending;

  // Line stores: raw pixels and filtered results, by raster position.
  pix_t raw_mem  [IMAGE_SIDE];
  pix_t filt_mem [IMAGE_SIDE];
  pix_t raw_rd;
  pix_t filt_rd;
  logic [LINE_AW-1:0] rd_addr;
  logic [LINE_AW-1:0] wr_addr;

  // Window registers; the left neighbour comes from the last result instead.
  pix_t top0;
  pix_t top1;
  pix_t top2;
  pix_t mid_c;
  pix_t mid_r;
  pix_t bot0;
  pix_t bot1;
  pix_t bot2;
  logic           v0;
  logic [Q_W-1:0] q0;

  logic [LINE_AW-1:0] row;
  logic [LINE_AW-1:0] col;
  logic      interior;
  logic      on_rect;
  sort_req_t req;
  sort_res_t res;
  pix_t      last_v;
  pix_t      med;
  pix_t      result;

  // Output queue.
  pix_t             oq_pix  [OQ_DEPTH];
  logic             oq_last [OQ_DEPTH];
  logic [OQ_AW-1:0] oq_wp;
  logic [OQ_AW-1:0] oq_rp;
  logic [OQ_CW-1:0] oq_count;
  logic             oq_pop;

  function automatic logic on_edge(input logic [LINE_AW-1:0] v,
                                   input logic [CORNER_W-1:0] start,
                                   input logic [LEN_W-1:0] len);
    logic [EDGE_W-1:0] vv;
    logic [EDGE_W-1:0] sv;
    logic [EDGE_W-1:0] far;
    vv  = EDGE_W'(v);
    sv  = EDGE_W'(start);
    far = sv + EDGE_W'(len);
    return (vv == sv) || (vv == sv + EDGE_W'(1)) ||
           (vv == far - EDGE_W'(1)) || (vv == far - EDGE_W'(2));
  endfunction

  // Issue: a request with a result needs room reserved in the output queue.
  assign inflight  = INFL_W'(v0) + INFL_W'(pending);
  assign credit_ok = ((OQ_CW + 1)'(oq_count) + (OQ_CW + 1)'(inflight)) <
                     (OQ_CW + 1)'(OQ_DEPTH);
  assign issue     = head_valid && (!head.has_result || credit_ok);
  assign head_pop  = issue;

  always_comb begin
    adv_pos_next = adv_pos;
    if (issue) begin
      if (adv_pos == POS_W'(ADV_LAST)) begin
        adv_pos_next = '0;
      end else begin
        adv_pos_next = adv_pos + POS_W'(1);
      end
    end
  end

  assign q_full  = adv_pos - POS_W'(LAG);
  assign rd_addr = adv_pos_next[LINE_AW-1:0];
  assign wr_addr = adv_pos[LINE_AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      adv_pos <= '0;
      v0      <= 1'b0;
    end else begin
      adv_pos <= adv_pos_next;
      v0      <= issue && head.has_result;
    end
  end

  // Line stores with registered reads, prefetched at the next position.
  always_ff @(posedge clk) begin
    raw_rd <= raw_mem[rd_addr];
    if (issue) begin
      raw_mem[wr_addr] <= head.pixel;
    end
  end

  always_ff @(posedge clk) begin
    filt_rd <= filt_mem[rd_addr];
    if (res.valid) begin
      filt_mem[res.meta.addr] <= result;
    end
  end

  // Window shift on every advance.
  always_ff @(posedge clk) begin
    if (issue) begin
      top0  <= top1;
      top1  <= top2;
      top2  <= filt_rd;
      mid_c <= mid_r;
      mid_r <= raw_rd;
      bot0  <= bot1;
      bot1  <= bot2;
      bot2  <= head.pixel;
      q0    <= q_full[Q_W-1:0];
    end
  end

  // Decide whether the centre pixel is filtered.
  assign row      = q0[Q_W-1:LINE_AW];
  assign col      = q0[LINE_AW-1:0];
  assign interior = (row != '0) && (row != LINE_AW'(IMAGE_SIDE - 1)) &&
                    (col != '0) && (col != LINE_AW'(IMAGE_SIDE - 1));
  assign on_rect  = on_edge(row, cfg.rect_top, cfg.rect_height) ||
                    on_edge(col, cfg.rect_left, cfg.rect_width);

  always_comb begin
    req.valid       = v0;
    req.meta.filt   = interior && on_rect && (mid_c > cfg.background_mean);
    req.meta.centre = mid_c;
    req.meta.last   = (q0 == Q_W'(FRAME_PIXELS - 1));
    req.meta.addr   = q0[LINE_AW-1:0];
    req.vals        = {bot2, bot1, bot0, mid_r, mid_c, top2, top1, top0};
  end

  recm_sort u_sort (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .res     (res),
    .pending (pending)
  );

  // The left neighbour is the previous result; clamping it between the
  // fourth and fifth of the other eight gives the median of nine.
  always_comb begin
    if (last_v <= res.lo) begin
      med = res.lo;
    end else if (last_v >= res.hi) begin
      med = res.hi;
    end else begin
      med = last_v;
    end
    result = res.meta.filt ? med : res.meta.centre;
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      last_v <= result;
    end
  end

  // Output queue; space was reserved at issue.
  assign oq_pop     = pop && !empty;
  assign empty      = (oq_count == '0);
  assign pixel_out  = oq_pix[oq_rp];
  assign frame_last = oq_last[oq_rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wp    <= '0;
      oq_rp    <= '0;
      oq_count <= '0;
    end else begin
      if (res.valid) begin
        oq_wp <= oq_wp + OQ_AW'(1);
      end
      if (oq_pop) begin
        oq_rp <= oq_rp + OQ_AW'(1);
      end
      oq_count <= oq_count + OQ_CW'(res.valid) - OQ_CW'(oq_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      oq_pix[oq_wp]  <= result;
      oq_last[oq_wp] <= res.meta.last;
    end
  end

  assign stat.oq_count = oq_count;
  assign stat.inflight = inflight;

endmodule

`default_nettype wire

[sv/rect_edge_conditional_median_unit.sv]
`default_nettype none

// Conditional 3x3 median filter for a 64x64 grey frame streamed in raster
// order, filtering in place: each window sees filtered pixels above and to
// the left. An interior pixel on the first two or last two rows or columns
// of the configured rectangle, and brighter than the background mean, is
// replaced by the median of its window. Results trail the input by one row
// plus one pixel; after the last pixel of a frame, 65 flush requests drain
// the remaining results, and frame_last marks the final one. The block takes
// one request per clock while full is low and gives one result per clock
// while pop is high and results wait, a rate set by the final stage, which
// clamps the previous result combinationally between two values from a
// three-stage sorting pipeline. A result passes the front queue, window
// registers, sort stages and output queue. The line stores need no clearing
// after reset. Write configuration only while idle.
module rect_edge_conditional_median_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              push,
  input  wire logic                              mode,
  input  wire logic [recm_pkg::PIX_W-1:0]        pixel_in,
  output logic                                   full,
  output logic                                   empty,
  input  wire logic                              pop,
  output logic [recm_pkg::PIX_W-1:0]             pixel_out,
  output logic                                   frame_last,
  input  wire logic                              cfg_write,
  input  wire logic [recm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [recm_pkg::PIX_W-1:0]        cfg_data
);
  import recm_pkg::*;

  cfg_t        cfg;
  mid_item_t   head;
  logic        head_valid;
  logic        head_pop;
  front_stat_t front_st;
  back_stat_t  back_st;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_RECT_LEFT:   cfg.rect_left       <= cfg_data[CORNER_W-1:0];
        CFG_RECT_TOP:    cfg.rect_top        <= cfg_data[CORNER_W-1:0];
        CFG_RECT_WIDTH:  cfg.rect_width      <= cfg_data[LEN_W-1:0];
        CFG_RECT_HEIGHT: cfg.rect_height     <= cfg_data[LEN_W-1:0];
        CFG_BG_MEAN:     cfg.background_mean <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  recm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .mode       (mode),
    .pixel_in   (pixel_in),
    .full       (full),
    .head       (head),
    .head_valid (head_valid),
    .head_pop   (head_pop),
    .stat       (front_st)
  );

  recm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head       (head),
    .head_valid (head_valid),
    .head_pop   (head_pop),
    .pixel_out  (pixel_out),
    .frame_last (frame_last),
    .empty      (empty),
    .pop        (pop),
    .stat       (back_st)
  );

  // Results in flight never exceed the space in the output queue.
  assert property (@(posedge clk) disable iff (rst)
    ((OQ_CW + 1)'(back_st.oq_count) + (OQ_CW + 1)'(back_st.inflight)) <=
    (OQ_CW + 1)'(OQ_DEPTH))
    else $error("output queue over-committed");

  // After reset both sides are open and nothing is waiting.
  assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not clear after reset");

  // A flush before the frame is complete leaves the frame count alone.
  assert property (@(posedge clk) disable iff (rst)
    (push && !full && (mode == MODE_FLUSH) &&
     (front_st.in_count != CNT_W'(FRAME_PIXELS))) |=> $stable(front_st.in_count))
    else $error("early flush changed the frame count");

  // The front end never hands over a request it does not hold.
  assert property (@(posedge clk) disable iff (rst) head_pop |-> head_valid)
    else $error("back end took a request from an empty queue");

endmodule

`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import recm_pkg::*;

  typedef struct packed {
    pix_t pixel;
    logic last;
  } grey_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 push = 1'b0;
  logic                 mode = MODE_PIXEL;
  pix_t                 pixel_in = '0;
  logic                 full;
  logic                 empty;
  logic                 pop = 1'b0;
  pix_t                 pixel_out;
  logic                 frame_last;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_RECT_LEFT;
  pix_t                 cfg_data = '0;

  // Own copy of the filter state: the whole frame by raster position, the
  // two frame counters and the rectangle settings.
  pix_t                frame_store [FRAME_PIXELS];
  int                  pixels_taken = 0;
  int                  pixels_given = 0;
  logic [CORNER_W-1:0] lim_left = '0;
  logic [CORNER_W-1:0] lim_top = '0;
  logic [LEN_W-1:0]    lim_width = '0;
  logic [LEN_W-1:0]    lim_height = '0;
  pix_t                grey_floor = '0;

  grey_result_t pending_pixels[$];
  grey_result_t oldest_pixel;
  int           mismatches = 0;
  logic         steady = 1'b0;

  rect_edge_conditional_median_unit u_top (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .mode       (mode),
    .pixel_in   (pixel_in),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .pixel_out  (pixel_out),
    .frame_last (frame_last),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  // True when v is one of the two first or two last lines of a span.
  function automatic bit on_border(int v, int start, int len);
    return v == start || v == start + 1 || v == start + len - 1 || v == start + len - 2;
  endfunction

  // Value given out for raster position q, from the frame as it stands now.
  function automatic pix_t filtered_value(int q);
    int   row;
    int   col;
    int   k;
    int   j;
    pix_t centre;
    pix_t key;
    pix_t win [9];
    row = q / IMAGE_SIDE;
    col = q % IMAGE_SIDE;
    centre = frame_store[q];
    if (row < 1 || row > IMAGE_SIDE - 2 || col < 1 || col > IMAGE_SIDE - 2)
      return centre;
    if (!(on_border(row, int'(lim_top), int'(lim_height)) ||
          on_border(col, int'(lim_left), int'(lim_width))))
      return centre;
    if (centre <= grey_floor)
      return centre;
    k = 0;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        win[k] = frame_store[(row + dr) * IMAGE_SIDE + col + dc];
        k++;
      end
    end
    // Insertion sort, then take the middle of nine.
    for (int i = 1; i < 9; i++) begin
      key = win[i];
      j = i - 1;
      while (j >= 0 && win[j] > key) begin
        win[j + 1] = win[j];
        j--;
      end
      win[j + 1] = key;
    end
    return win[4];
  endfunction

  // Advance the frame state for one accepted request and queue its result.
  task automatic track_request(input logic m, input pix_t px);
    int           p;
    int           q;
    pix_t         v;
    grey_result_t fresh;
    if (m == MODE_PIXEL) begin
      if (pixels_taken >= FRAME_PIXELS)
        return;
      p = pixels_taken;
      pixels_taken++;
      frame_store[p] = px;
      if (p < LAG)
        return;
      q = p - LAG;
    end else begin
      if (pixels_taken < FRAME_PIXELS || pixels_given >= FRAME_PIXELS)
        return;
      q = pixels_given;
    end
    v = filtered_value(q);
    frame_store[q] = v;
    fresh.pixel = v;
    fresh.last  = (q == FRAME_PIXELS - 1);
    pending_pixels.insert(pending_pixels.size(), fresh);
    pixels_given = q + 1;
    if (pixels_given >= FRAME_PIXELS) begin
      pixels_given = 0;
      pixels_taken = 0;
    end
  endtask

  // Offer one request, wait for it to be taken, then maybe idle a little.
  task automatic send_request(input logic m, input pix_t px);
    push     <= 1'b1;
    mode     <= m;
    pixel_in <= px;
    @(posedge clk);
    while (full)
      @(posedge clk);
    track_request(m, px);
    if (!steady && $urandom_range(99) < 7) begin
      push <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
  endtask

  // Stop sending and wait until every expected result has come out.
  task automatic settle();
    push <= 1'b0;
    while (pending_pixels.size() != 0)
      @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[PIX_W-1:0];
    @(posedge clk);
    case (idx)
      CFG_RECT_LEFT:   lim_left   = value[CORNER_W-1:0];
      CFG_RECT_TOP:    lim_top    = value[CORNER_W-1:0];
      CFG_RECT_WIDTH:  lim_width  = value[LEN_W-1:0];
      CFG_RECT_HEIGHT: lim_height = value[LEN_W-1:0];
      CFG_BG_MEAN:     grey_floor = value[PIX_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_rect(input int left, input int top, input int width,
                            input int height, input int mean);
    put_reg(CFG_RECT_LEFT, left);
    put_reg(CFG_RECT_TOP, top);
    put_reg(CFG_RECT_WIDTH, width);
    put_reg(CFG_RECT_HEIGHT, height);
    put_reg(CFG_BG_MEAN, mean);
    cfg_write <= 1'b0;
  endtask

  task automatic apply_random_rect();
    apply_rect($urandom_range(63), $urandom_range(63), $urandom_range(64),
               $urandom_range(64), $urandom_range(255));
  endtask

  // Grey levels biased to the extremes and to the threshold itself.
  function automatic pix_t random_grey();
    int g;
    case ($urandom_range(9))
      0: g = 0;
      1: g = 255;
      2, 3: g = int'(grey_floor) + $urandom_range(6) - 3;
      default: g = $urandom_range(255);
    endcase
    if (g < 0)
      g = 0;
    if (g > 255)
      g = 255;
    return pix_t'(g);
  endfunction

  // A flush before any frame has arrived has nothing to drain.
  task automatic test_flush_before_frame();
    send_request(MODE_FLUSH, 8'h00);
    send_request(MODE_FLUSH, 8'hFF);
    send_request(MODE_FLUSH, pix_t'($urandom_range(255)));
  endtask

  // Opening pixels at the extremes and in the middle of the grey range, under reset settings.
  task automatic test_extreme_pixels();
    pix_t levels [16] = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h01, 8'hFE, 8'h80, 8'h7F,
                          8'h55, 8'hAA, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h0F, 8'hF0};
    foreach (levels[i])
      send_request(MODE_PIXEL, levels[i]);
  endtask

  // The upper part of the first frame in phases, each with its own rectangle,
  // including full-image, degenerate and unreachable-threshold settings.
  // Flushes sent meanwhile come before the frame is complete and are dropped.
  task automatic test_rect_phases();
    int target;
    for (int ph = 0; ph < 10; ph++) begin
      if (ph > 0) begin
        settle();
        case (ph)
          1: apply_rect(0, 0, 64, 64, 0);
          2: apply_rect(63, 63, 64, 64, 255);
          3: apply_rect(20, 12, 1, 1, 100);
          4: apply_rect(5, 30, 0, 0, 60);
          5: apply_rect(30, 10, 10, 8, 128);
          6: apply_rect(0, 0, 2, 2, $urandom_range(200));
          default: apply_random_rect();
        endcase
      end
      // One phase runs with no idling on either side.
      steady = (ph == 5);
      target = (ph + 1) * 190;
      while (pixels_taken < target) begin
        if ($urandom_range(99) < 3)
          send_request(MODE_FLUSH, pix_t'($urandom_range(255)));
        else
          send_request(MODE_PIXEL, random_grey());
      end
    end
    steady = 1'b0;
  endtask

  // Result side: random stalls, each accepted result compared in order.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (pending_pixels.size() == 0) begin
          $display("%0t: unexpected result, pixel_out %0d frame_last %0b",
                   $time, pixel_out, frame_last);
          mismatches++;
        end else begin
          oldest_pixel = pending_pixels.pop_front();
          if (pixel_out !== oldest_pixel.pixel) begin
            $display("%0t: pixel_out expected %0d, actual %0d",
                     $time, oldest_pixel.pixel, pixel_out);
            mismatches++;
          end
          if (frame_last !== oldest_pixel.last) begin
            $display("%0t: frame_last expected %0b, actual %0b",
                     $time, oldest_pixel.last, frame_last);
            mismatches++;
          end
        end
      end
      pop <= steady || ($urandom_range(99) >= 14);
    end
  end

  initial begin
    foreach (frame_store[i])
      frame_store[i] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_flush_before_frame();
    test_extreme_pixels();
    test_rect_phases();
    settle();
    if (mismatches == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #3000000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule

[sim.f]
sv/recm_pkg.sv
sv/recm_front.sv
sv/recm_sort.sv
sv/recm_back.sv
sv/rect_edge_conditional_median_unit.sv
verif/tb_top.sv
